@@ rtl/core/ray_aabox_entry_test_assert.svh @@
// Assertion macros used by the RTL of the ray / box entry test.
`ifndef RAY_AABOX_ENTRY_TEST_ASSERT_SVH
`define RAY_AABOX_ENTRY_TEST_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define RAET_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Trigger at one edge implies the consequence at the next edge.
`define RAET_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/raet_pkg.sv @@
package raet_pkg;

  // Direction magnitude must exceed this (raw LSBs) for an axis to count
  localparam int unsigned DIR_EPS = 1;
  // Widening of the box for the hit point check (raw LSBs)
  localparam int unsigned HIT_EPS = 66;
  // One quotient bit per divider stage
  localparam int unsigned DIV_STAGES = 32;
  // Start value of the running maximum: -1.0 in Q16.16
  localparam logic signed [31:0] T_INIT = -32'sd65536;
  localparam logic [30:0] MAX_T_RST = 31'h7FFF_FFFF;

  typedef logic signed [31:0] q16_t;

  // Geometry carried along the pipeline
  typedef struct packed {
    q16_t [2:0] s;
    q16_t [2:0] d;
    q16_t [2:0] lo;
    q16_t [2:0] hi;
    logic       start_in;
  } geo_t;

  // Per-axis state of the restoring divider
  typedef struct packed {
    logic        en;   // axis direction usable
    logic        neg;  // quotient sign
    logic        ovf;  // quotient magnitude >= 2^32
    logic [31:0] dv;   // divisor magnitude
    logic [31:0] rem;  // partial remainder
    logic [31:0] sh;   // remaining dividend bits, quotient shifts in
  } div_t;

  // One restoring division step
  function automatic div_t div_step(div_t x);
    div_t        y;
    logic [32:0] r2;
    logic [32:0] df;
    y  = x;
    r2 = {x.rem, x.sh[31]};
    df = r2 - {1'b0, x.dv};
    if (r2 >= {1'b0, x.dv}) begin
      y.rem = df[31:0];
      y.sh  = {x.sh[30:0], 1'b1};
    end else begin
      y.rem = r2[31:0];
      y.sh  = {x.sh[30:0], 1'b0};
    end
    return y;
  endfunction

endpackage

@@ rtl/core/ray_aabox_entry_test.sv @@
// Channel | Dir | Handshake                   | Payload
// in      | in  | in_valid_i / in_stall_o     | start_*, dir_*, box_min_*, box_max_*
// out     | out | out_valid_o / out_stall_i   | hit_o, entry_t_o
// cfg     | in  | cfg_valid_i / cfg_ready_o   | cfg_data_i (max_t)
//
// One transaction per cycle while the output is not stalled; the result passes through
// setup, 32 restoring divider stages (one quotient bit each), saturate, maximum,
// multiply, hit point and box check, 38 registers in all.
// The whole pipeline advances together: a held result stalls every stage.
// Reset clears all valid bits and loads max_t with its full-range value.
module ray_aabox_entry_test (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  raet_pkg::q16_t start_x_i,
  input  raet_pkg::q16_t start_y_i,
  input  raet_pkg::q16_t start_z_i,
  input  raet_pkg::q16_t dir_x_i,
  input  raet_pkg::q16_t dir_y_i,
  input  raet_pkg::q16_t dir_z_i,
  input  raet_pkg::q16_t box_min_x_i,
  input  raet_pkg::q16_t box_min_y_i,
  input  raet_pkg::q16_t box_min_z_i,
  input  raet_pkg::q16_t box_max_x_i,
  input  raet_pkg::q16_t box_max_y_i,
  input  raet_pkg::q16_t box_max_z_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        hit_o,
  output logic [30:0] entry_t_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [30:0] cfg_data_i
);
  import raet_pkg::*;
  `include "ray_aabox_entry_test_assert.svh"

  logic        adv;
  logic [30:0] max_t_q;

  geo_t        geo_d;
  div_t [2:0]  div_d;

  logic        vld_q [DIV_STAGES+1];
  geo_t        geo_q [DIV_STAGES+1];
  div_t [2:0]  div_q [DIV_STAGES+1];

  // post-divide stages
  logic        sat_vld_q, max_vld_q, mul_vld_q, add_vld_q;
  geo_t        sat_geo_q, max_geo_q, mul_geo_q, add_geo_q;
  q16_t [2:0]  sat_t_q;
  q16_t        max_t_d, max_tv_q, mul_t_q, add_t_q;
  logic        max_ok_q, mul_ok_q, add_ok_q;
  logic signed [63:0] mul_p_q [3];
  logic signed [48:0] add_pt_q [3];

  logic        hit_q;
  logic [30:0] entry_t_q;
  logic        out_vld_q;

  assign adv         = !(out_vld_q && out_stall_i);
  assign in_stall_o  = !adv;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_vld_q;
  assign hit_o       = hit_q;
  assign entry_t_o   = entry_t_q;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_t_q <= MAX_T_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_t_q <= cfg_data_i;
    end
  end

  // setup: inside test, entry plane distance, divider operands
  always_comb begin
    logic signed [32:0] diff;
    logic        [32:0] nabs;
    q16_t               plane;
    logic        [31:0] dmag;
    geo_d.s      = '{start_z_i, start_y_i, start_x_i};
    geo_d.d      = '{dir_z_i, dir_y_i, dir_x_i};
    geo_d.lo     = '{box_min_z_i, box_min_y_i, box_min_x_i};
    geo_d.hi     = '{box_max_z_i, box_max_y_i, box_max_x_i};
    geo_d.start_in = 1'b1;
    diff  = '0;
    nabs  = '0;
    plane = '0;
    dmag  = '0;
    for (int a = 0; a < 3; a++) begin
      if ($signed(geo_d.s[a]) < $signed(geo_d.lo[a]) ||
          $signed(geo_d.s[a]) > $signed(geo_d.hi[a])) begin
        geo_d.start_in = 1'b0;
      end
      plane = geo_d.d[a][31] ? geo_d.hi[a] : geo_d.lo[a];
      diff  = {plane[31], plane} - {geo_d.s[a][31], geo_d.s[a]};
      nabs  = diff[32] ? 33'(-diff) : diff;
      dmag  = geo_d.d[a][31] ? 32'(-geo_d.d[a]) : geo_d.d[a];
      div_d[a].en  = dmag > 32'(DIR_EPS);
      div_d[a].neg = diff[32] ^ geo_d.d[a][31];
      div_d[a].ovf = {16'b0, nabs[31:16]} >= dmag;
      div_d[a].dv  = dmag;
      div_d[a].rem = {16'b0, nabs[31:16]};
      div_d[a].sh  = {nabs[15:0], 16'b0};
    end
  end

  // divider pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= DIV_STAGES; k++) vld_q[k] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_valid_i;
      for (int k = 0; k < DIV_STAGES; k++) vld_q[k+1] <= vld_q[k];
    end
  end

  // divider pipeline data: one quotient bit per stage
  always_ff @(posedge clk_i) begin
    if (adv) begin
      geo_q[0] <= geo_d;
      div_q[0] <= div_d;
      for (int k = 0; k < DIV_STAGES; k++) begin
        geo_q[k+1] <= geo_q[k];
        for (int a = 0; a < 3; a++) div_q[k+1][a] <= div_step(div_q[k][a]);
      end
    end
  end

  // running maximum over the saturated quotients
  always_comb begin
    q16_t m01, m2;
    m01     = ($signed(sat_t_q[0]) > $signed(sat_t_q[1])) ? sat_t_q[0] : sat_t_q[1];
    m2      = ($signed(sat_t_q[2]) > $signed(T_INIT)) ? sat_t_q[2] : T_INIT;
    max_t_d = ($signed(m01) > $signed(m2)) ? m01 : m2;
  end

  // tail valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_vld_q <= 1'b0;
      max_vld_q <= 1'b0;
      mul_vld_q <= 1'b0;
      add_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      sat_vld_q <= vld_q[DIV_STAGES];
      max_vld_q <= sat_vld_q;
      mul_vld_q <= max_vld_q;
      add_vld_q <= mul_vld_q;
      out_vld_q <= add_vld_q;
    end
  end

  // tail data: saturate, maximum, multiply, hit point, box check
  always_ff @(posedge clk_i) begin
    logic               allin;
    logic signed [63:0] rnd;
    logic signed [48:0] lim_lo, lim_hi;
    if (adv) begin
      // saturate and apply sign
      sat_geo_q <= geo_q[DIV_STAGES];
      for (int a = 0; a < 3; a++) begin
        if (!div_q[DIV_STAGES][a].en) begin
          sat_t_q[a] <= T_INIT;
        end else if (!div_q[DIV_STAGES][a].neg) begin
          sat_t_q[a] <= (div_q[DIV_STAGES][a].ovf || div_q[DIV_STAGES][a].sh[31]) ?
                        32'sh7FFF_FFFF : div_q[DIV_STAGES][a].sh;
        end else begin
          sat_t_q[a] <= (div_q[DIV_STAGES][a].ovf ||
                         div_q[DIV_STAGES][a].sh > 32'h8000_0000) ?
                        32'sh8000_0000 : 32'(-div_q[DIV_STAGES][a].sh);
        end
      end
      // maximum and range check
      max_geo_q <= sat_geo_q;
      max_tv_q  <= max_t_d;
      max_ok_q  <= !max_t_d[31] && (max_t_d[30:0] < max_t_q);
      // direction times t
      mul_geo_q <= max_geo_q;
      mul_t_q   <= max_tv_q;
      mul_ok_q  <= max_ok_q;
      for (int a = 0; a < 3; a++) begin
        mul_p_q[a] <= $signed(max_geo_q.d[a]) * $signed(max_tv_q);
      end
      // truncate toward zero, add start
      add_geo_q <= mul_geo_q;
      add_t_q   <= mul_t_q;
      add_ok_q  <= mul_ok_q;
      for (int a = 0; a < 3; a++) begin
        rnd = mul_p_q[a] + (mul_p_q[a][63] ? 64'sd65535 : 64'sd0);
        add_pt_q[a] <= 49'($signed(rnd) >>> 16) +
                       {{17{mul_geo_q.s[a][31]}}, mul_geo_q.s[a]};
      end
      // widened box check and result
      allin = 1'b1;
      for (int a = 0; a < 3; a++) begin
        lim_lo = {{17{add_geo_q.lo[a][31]}}, add_geo_q.lo[a]} - 49'(HIT_EPS);
        lim_hi = {{17{add_geo_q.hi[a][31]}}, add_geo_q.hi[a]} + 49'(HIT_EPS);
        if (add_pt_q[a] < lim_lo || add_pt_q[a] > lim_hi) allin = 1'b0;
      end
      if (add_geo_q.start_in) begin
        hit_q     <= 1'b1;
        entry_t_q <= '0;
      end else if (add_ok_q && allin) begin
        hit_q     <= 1'b1;
        entry_t_q <= add_t_q[30:0];
      end else begin
        hit_q     <= 1'b0;
        entry_t_q <= '0;
      end
    end
  end

  // checks
  `RAET_ASSERT_ALWAYS(a_miss_zero, !(out_vld_q && !hit_q) || entry_t_q == '0,
                      "miss with nonzero entry_t")
  `RAET_ASSERT_ALWAYS(a_t_below_max, !(out_vld_q && hit_q && entry_t_q != '0) ||
                      entry_t_q < max_t_q, "entry_t not below max_t")
  `RAET_ASSERT_NEXT(a_enter, in_valid_i && !in_stall_o, vld_q[0],
                    "accepted transaction not in pipeline")
  `RAET_ASSERT_NEXT(a_hold, in_stall_o, vld_q[0] == $past(vld_q[0]) &&
                    sat_vld_q == $past(sat_vld_q), "pipeline moved under stall")

endmodule

@@ tb/ray_aabox_entry_test_tb.sv @@
module ray_aabox_entry_test_tb;
  import raet_pkg::*;

  localparam int unsigned RAND_RAYS = 1600;
  localparam int unsigned LATENCY = 38;
  localparam longint unsigned CYCLE_LIMIT = 400000;

  // One ray/box query and its expected outcome
  typedef struct {
    q16_t [2:0] s;
    q16_t [2:0] d;
    q16_t [2:0] lo;
    q16_t [2:0] hi;
  } ray_query_t;

  typedef struct {
    logic        hit;
    logic [30:0] entry_t;
  } entry_result_t;

  // Directed row: query, and optionally a typed-in expectation
  typedef struct {
    ray_query_t    q;
    logic          fixed;
    entry_result_t res;
  } directed_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  q16_t        start_x_i, start_y_i, start_z_i;
  q16_t        dir_x_i, dir_y_i, dir_z_i;
  q16_t        box_min_x_i, box_min_y_i, box_min_z_i;
  q16_t        box_max_x_i, box_max_y_i, box_max_z_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        hit_o;
  logic [30:0] entry_t_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [30:0] cfg_data_i;

  ray_aabox_entry_test u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .start_z_i   (start_z_i),
    .dir_x_i     (dir_x_i),
    .dir_y_i     (dir_y_i),
    .dir_z_i     (dir_z_i),
    .box_min_x_i (box_min_x_i),
    .box_min_y_i (box_min_y_i),
    .box_min_z_i (box_min_z_i),
    .box_max_x_i (box_max_x_i),
    .box_max_y_i (box_max_y_i),
    .box_max_z_i (box_max_z_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .hit_o       (hit_o),
    .entry_t_o   (entry_t_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // Predictor state
  logic [30:0]   t_limit;
  entry_result_t pending_hits[$];
  int unsigned   n_errors;
  int unsigned   n_results;
  int unsigned   n_hits;
  int unsigned   n_inside;
  longint unsigned cycle_cnt;
  logic          long_hold;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Truncating division toward zero on 64-bit values
  function automatic longint trunc_div(longint n, longint d);
    longint an, ad, qq;
    an = (n < 0) ? -n : n;
    ad = (d < 0) ? -d : d;
    qq = an / ad;
    return ((n < 0) != (d < 0)) ? -qq : qq;
  endfunction

  // Slab entry prediction
  function automatic entry_result_t predict_entry(ray_query_t q, logic [30:0] lim);
    entry_result_t r;
    longint s, d, lo, hi, t, mag, plane, qq, p;
    logic start_in, ok;
    start_in = 1'b1;
    t = -65536;
    ok = 1'b1;
    for (int a = 0; a < 3; a++) begin
      if (q.s[a] < q.lo[a] || q.s[a] > q.hi[a]) start_in = 1'b0;
    end
    if (start_in) begin
      r.hit = 1'b1;
      r.entry_t = '0;
      return r;
    end
    for (int a = 0; a < 3; a++) begin
      s = q.s[a];
      d = q.d[a];
      mag = (d < 0) ? -d : d;
      if (mag > longint'(DIR_EPS)) begin
        plane = (d > 0) ? longint'(q.lo[a]) : longint'(q.hi[a]);
        qq = trunc_div((plane - s) * 65536, d);
        if (qq > 64'sd2147483647) qq = 64'sd2147483647;
        if (qq < -64'sd2147483648) qq = -64'sd2147483648;
        if (qq > t) t = qq;
      end
    end
    if (t < 0 || t >= longint'({1'b0, lim})) ok = 1'b0;
    for (int a = 0; a < 3 && ok; a++) begin
      s = q.s[a];
      d = q.d[a];
      lo = q.lo[a];
      hi = q.hi[a];
      p = s + trunc_div(d * t, 65536);
      if (p < lo - longint'(HIT_EPS) || p > hi + longint'(HIT_EPS)) ok = 1'b0;
    end
    r.hit = ok;
    r.entry_t = ok ? t[30:0] : '0;
    return r;
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    entry_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (pending_hits.size() == 0) begin
        $error("unexpected result hit=%0b entry_t=%0h", hit_o, entry_t_o);
        n_errors++;
      end else begin
        e = pending_hits.pop_front();
        if (hit_o !== e.hit) begin
          $error("hit: expected %0b actual %0b", e.hit, hit_o);
          n_errors++;
        end
        if (entry_t_o !== e.entry_t) begin
          $error("entry_t: expected %0h actual %0h", e.entry_t, entry_t_o);
          n_errors++;
        end
        if (e.hit) n_hits++;
      end
    end
  end

  // Receiver: stalls in short runs, with a long hold-off on request
  initial begin
    int unsigned mode;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_stall_i <= 1'b1;
        repeat (120) @(posedge clk_i);
        out_stall_i <= 1'b0;
        long_hold = 1'b0;
      end else begin
        mode = (cycle_cnt / 500) % 3;
        if (mode == 0) out_stall_i <= 1'b0;
        else if (mode == 1) out_stall_i <= ($urandom_range(0, 3) == 0);
        else out_stall_i <= ($urandom_range(0, 1) == 0);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Offer one transaction and hold it until accepted
  task automatic send_ray(ray_query_t q, logic fixed, entry_result_t want);
    entry_result_t r;
    in_valid_i  <= 1'b1;
    start_x_i   <= q.s[0];  start_y_i   <= q.s[1];  start_z_i   <= q.s[2];
    dir_x_i     <= q.d[0];  dir_y_i     <= q.d[1];  dir_z_i     <= q.d[2];
    box_min_x_i <= q.lo[0]; box_min_y_i <= q.lo[1]; box_min_z_i <= q.lo[2];
    box_max_x_i <= q.hi[0]; box_max_y_i <= q.hi[1]; box_max_z_i <= q.hi[2];
    do @(posedge clk_i); while (in_stall_o);
    r = predict_entry(q, t_limit);
    if (fixed && (r.hit !== want.hit || r.entry_t !== want.entry_t))
      $display("note: table row differs from prediction");
    pending_hits.push_back(fixed ? want : r);
    if (r.hit && q.s[0] >= q.lo[0] && q.s[0] <= q.hi[0] && r.entry_t == 0) n_inside++;
  endtask

  task automatic idle_cycles(int unsigned n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [30:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    t_limit = v;
  endtask

  function automatic q16_t rand_word();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return -32'sh8000_0000;
      2: return q16_t'($urandom_range(0, 4) - 2);
      default: return q16_t'($urandom());
    endcase
  endfunction

  // Ray aimed roughly at a box centre; with wild set, random words in every field
  function automatic ray_query_t rand_ray(bit wild);
    ray_query_t q;
    int signed c, h;
    for (int a = 0; a < 3; a++) begin
      if (wild) begin
        q.s[a] = rand_word();
        q.d[a] = rand_word();
        q.lo[a] = rand_word();
        q.hi[a] = rand_word();
      end else begin
        c = $urandom_range(0, 40 << 16) - (20 << 16);
        h = $urandom_range(1, 8 << 16);
        q.lo[a] = c - h;
        q.hi[a] = c + h;
        q.s[a] = $urandom_range(0, 200 << 16) - (100 << 16);
        q.d[a] = q16_t'((c - q.s[a]) / 8 + int'($urandom_range(0, 2000)) - 1000);
        if ($urandom_range(0, 15) == 0) q.d[a] = q16_t'($urandom_range(0, 2) - 1);
      end
    end
    return q;
  endfunction

  function automatic ray_query_t mk(int s0, int d0, int lo0, int hi0);
    ray_query_t q;
    for (int a = 0; a < 3; a++) begin
      q.s[a] = s0; q.d[a] = d0; q.lo[a] = lo0; q.hi[a] = hi0;
    end
    return q;
  endfunction

  // Stimulus
  initial begin
    directed_row_t rows[$];
    directed_row_t row;
    ray_query_t    q;
    entry_result_t none;
    int unsigned   sent, burst;
    logic [30:0]   limits[4];

    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    {start_x_i, start_y_i, start_z_i, dir_x_i, dir_y_i, dir_z_i} = '0;
    {box_min_x_i, box_min_y_i, box_min_z_i, box_max_x_i, box_max_y_i, box_max_z_i} = '0;
    t_limit = MAX_T_RST;
    n_errors = 0; n_results = 0; n_hits = 0; n_inside = 0;
    cycle_cnt = 0;
    long_hold = 1'b0;
    none.hit = 1'b0; none.entry_t = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: inside, zero dir, extremes, saturation, inverted box
    row.fixed = 1'b1; row.res.hit = 1'b1; row.res.entry_t = '0;
    row.q = mk(0, 0, -65536, 65536); rows.push_back(row);
    row.q = mk(-32'sh8000_0000, 5, -32'sh8000_0000, 32'sh7FFF_FFFF); rows.push_back(row);
    row.res = none;
    row.q = mk(10 << 16, 0, 0, 65536); rows.push_back(row);
    row.q = mk(10 << 16, 1, 0, 65536); rows.push_back(row);
    row.q = mk(10 << 16, -1, 0, 65536); rows.push_back(row);
    row.q = mk(0, 65536, 65536, 0); rows.push_back(row);
    row.fixed = 1'b0;
    row.q = mk(-10 << 16, 65536, 0, 65536); rows.push_back(row);
    row.q = mk(10 << 16, -65536, 0, 65536); rows.push_back(row);
    row.q = mk(-32'sh8000_0000, 2, 32'sh7FFF_FFF0, 32'sh7FFF_FFFF); rows.push_back(row);
    row.q = mk(32'sh7FFF_FFFF, -32'sh8000_0000, -32'sh8000_0000, 0); rows.push_back(row);
    row.q = mk(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, -32'sh8000_0000, 0); rows.push_back(row);
    row.q = mk(-2 << 16, 2, -65536, 65536); rows.push_back(row);
    row.q = mk(-5 << 16, 65536, 0, 65536);
    row.q.d[1] = 65536 + 3; row.q.s[1] = -(5 << 16) - 200; rows.push_back(row);
    row.q = mk(-5 << 16, 65536, 0, 65536); row.q.d[2] = -65536; rows.push_back(row);
    row.q = mk(-1, 2, 0, 0); rows.push_back(row);
    row.q = mk(-32'sh8000_0000, -32'sh8000_0000, 32'sh7FFF_FFFF, -32'sh8000_0000);
    rows.push_back(row);
    foreach (rows[i]) send_ray(rows[i].q, rows[i].fixed, rows[i].res);
    drain_results();

    // Random phases across limit settings, extremes included
    limits[0] = 31'h7FFF_FFFF; limits[1] = 31'd0; limits[2] = 31'd5 << 16;
    limits[3] = 31'd1;
    sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      write_limit(limits[ph]);
      if (ph == 1) long_hold = 1'b1;
      while (sent < (ph + 1) * RAND_RAYS / 4) begin
        burst = $urandom_range(1, 30);
        for (int k = 0; k < burst; k++) begin
          q = rand_ray($urandom_range(0, 4) == 0);
          send_ray(q, 1'b0, none);
          sent++;
        end
        if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 6));
      end
      drain_results();
    end

    $display("covered %0d results, %0d hits, over %0d limit settings",
             n_results, n_hits, 4);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
